// ===== rtl/core/fcs_pkg.sv =====
package fcs_pkg;

   // Fixed field widths of the channels.
   localparam int KIND_BITS        = 3;
   localparam int WEIGHT_PORT_BITS = 16;
   localparam int SEL_BITS         = 3;
   localparam int COUNT_BITS       = 9;
   localparam int TOTAL_BITS       = 24;
   localparam int CSR_INDEX_BITS   = 3;
   localparam int CSR_DATA_BITS    = 24;

   // Capacity registers; stacks beyond these have a capacity of zero.
   localparam int NUM_CAPS      = 4;
   localparam int CAP_IDX_BITS  = 2;

   // Defaults of the top level parameters.
   localparam int DEF_FIFO_DEPTH  = 256;
   localparam int DEF_NUM_STACKS  = 4;
   localparam int DEF_STACK_DEPTH = 64;
   localparam int DEF_WEIGHT_BITS = 16;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_ADD    = 3'd0,
      KIND_LOAD   = 3'd1,
      KIND_DELETE = 3'd2,
      KIND_INFO   = 3'd3,
      KIND_CLEAR  = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_LOAD_CHK,
      ST_LOAD_MOV,
      ST_DEL_SUB,
      ST_DONE
   } state_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      alu_op_type            op;
      logic [TOTAL_BITS-1:0] a;
      logic [TOTAL_BITS-1:0] b;
      logic [TOTAL_BITS-1:0] limit;
   } alu_req_type;

   typedef struct packed {
      logic [TOTAL_BITS-1:0] result;
      logic                  over;
   } alu_rsp_type;

endpackage

// ===== rtl/core/fcs_if.sv =====
interface fcs_req_if;
   import fcs_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [KIND_BITS-1:0]        kind;
   logic [WEIGHT_PORT_BITS-1:0] weight;
   logic [SEL_BITS-1:0]         stack_sel;

   modport source (output valid, kind, weight, stack_sel, input ready);
   modport sink (input valid, kind, weight, stack_sel, output ready);
endinterface

interface fcs_rsp_if;
   import fcs_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [SEL_BITS-1:0]   echo_stack;
   logic [COUNT_BITS-1:0] item_count;
   logic [TOTAL_BITS-1:0] total_weight;
   logic                  error_flag;

   modport source (output valid, echo_stack, item_count, total_weight, error_flag,
                   input ready);
   modport sink (input valid, echo_stack, item_count, total_weight, error_flag,
                 output ready);
endinterface

interface fcs_csr_if;
   import fcs_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/fcs_alu.sv =====
module fcs_alu (
   input  fcs_pkg::alu_req_type alu_req,
   output fcs_pkg::alu_rsp_type alu_rsp
);
   import fcs_pkg::*;

   logic [TOTAL_BITS:0]   sum_wide;
   logic [TOTAL_BITS-1:0] diff;

   // The compare uses the full sum so a carry out still counts as over.
   assign sum_wide = {1'b0, alu_req.a} + {1'b0, alu_req.b};
   assign diff     = alu_req.a - alu_req.b;

   always_comb begin
      alu_rsp.over   = sum_wide > {1'b0, alu_req.limit};
      alu_rsp.result = (alu_req.op == ALU_ADD) ? sum_wide[TOTAL_BITS-1:0] : diff;
   end

endmodule

// ===== rtl/core/fcs_stores.sv =====
module fcs_stores #(
   parameter int FIFO_DEPTH  = fcs_pkg::DEF_FIFO_DEPTH,
   parameter int NUM_STACKS  = fcs_pkg::DEF_NUM_STACKS,
   parameter int STACK_DEPTH = fcs_pkg::DEF_STACK_DEPTH,
   parameter int WEIGHT_BITS = fcs_pkg::DEF_WEIGHT_BITS
) (
   input  logic                                      clock,
   input  logic                                      fifo_we,
   input  logic [$clog2(FIFO_DEPTH)-1:0]             fifo_waddr,
   input  logic [WEIGHT_BITS-1:0]                    fifo_wdata,
   input  logic [$clog2(FIFO_DEPTH)-1:0]             fifo_raddr,
   output logic [WEIGHT_BITS-1:0]                    fifo_rdata,
   input  logic                                      stack_we,
   input  logic [$clog2(NUM_STACKS*STACK_DEPTH)-1:0] stack_addr,
   input  logic [WEIGHT_BITS-1:0]                    stack_wdata,
   output logic [WEIGHT_BITS-1:0]                    stack_rdata
);
   localparam int STACK_WORDS = NUM_STACKS * STACK_DEPTH;

   logic [WEIGHT_BITS-1:0] fifo_mem  [FIFO_DEPTH];
   logic [WEIGHT_BITS-1:0] stack_mem [STACK_WORDS];
   logic [WEIGHT_BITS-1:0] fifo_rdata_ff;
   logic [WEIGHT_BITS-1:0] stack_rdata_ff;

   always_ff @(posedge clock) begin
      if (fifo_we) begin
         fifo_mem[fifo_waddr] <= fifo_wdata;
      end
      fifo_rdata_ff <= fifo_mem[fifo_raddr];
   end

   // The stacks share one address; a load writes it and a delete reads it.
   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_addr] <= stack_wdata;
      end
      stack_rdata_ff <= stack_mem[stack_addr];
   end

   assign fifo_rdata  = fifo_rdata_ff;
   assign stack_rdata = stack_rdata_ff;

endmodule

// ===== rtl/core/fifo_to_capacity_stacks_unit.sv =====
// A shared FIFO of item weights feeding a set of LIFO stacks, each stack limited by a
// weight capacity register (cap_0..cap_3, written through the csr_ channel at any index;
// writes to an index past the last register are ignored, stacks past the fourth have a
// capacity of zero). Each request beat is one command and gives exactly one response
// beat: add appends a weight to the FIFO tail and reports the FIFO count and total
// (a full FIFO drops it and sets error_flag); load moves items from the FIFO head onto
// the selected stack until the FIFO is empty, the stack is full, or the next item would
// lift the stack total above its capacity, and reports the stack count; delete pops the
// top of a stack; info reports a stack's count and total; clear empties the FIFO and all
// stacks but keeps the capacities. A bad stack index on load, delete or info, or an unknown
// kind, changes nothing and sets error_flag. After acceptance every command passes the
// EXEC state and then DONE, which hands the response beat to the response register;
// delete on a non-empty stack passes DEL_SUB between them, and load on a good index goes
// through LOAD_CHK and, per moved item, LOAD_MOV and back to LOAD_CHK. Each moved item
// uses the one shared adder/comparator twice, once to test the stack total against the
// capacity and once to take the item out of the FIFO total, and the FIFO memory read is
// registered. One command is worked at a time; the next request beat is taken once the
// current response is handed to the response register, even while that beat still waits
// on rsp_if.ready. Neither the request nor the capacity channel is ready while reset is
// high. No clearing pass is needed after reset.
module fifo_to_capacity_stacks_unit #(
   parameter int FIFO_DEPTH  = fcs_pkg::DEF_FIFO_DEPTH,
   parameter int NUM_STACKS  = fcs_pkg::DEF_NUM_STACKS,
   parameter int STACK_DEPTH = fcs_pkg::DEF_STACK_DEPTH,
   parameter int WEIGHT_BITS = fcs_pkg::DEF_WEIGHT_BITS
) (
   input logic         clock,
   input logic         reset,
   fcs_req_if.sink     req_if,
   fcs_rsp_if.source   rsp_if,
   fcs_csr_if.sink     csr_if
);
   import fcs_pkg::*;

   localparam int FAW  = $clog2(FIFO_DEPTH);
   localparam int FCW  = $clog2(FIFO_DEPTH + 1);
   localparam int SCW  = $clog2(STACK_DEPTH + 1);
   localparam int SELW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam int SAW  = $clog2(NUM_STACKS * STACK_DEPTH);
   localparam int WUSE = (WEIGHT_BITS < WEIGHT_PORT_BITS) ? WEIGHT_BITS : WEIGHT_PORT_BITS;

   // Sequencer state and the latched command.
   state_type             state_ff, state_in;
   logic [KIND_BITS-1:0]  kind_ff, kind_in;
   logic [WEIGHT_BITS-1:0] weight_ff, weight_in;
   logic [SEL_BITS-1:0]   sel_ff, sel_in;
   logic                  err_ff, err_in;

   // FIFO bookkeeping and per-stack bookkeeping.
   logic [FAW-1:0]        head_ff, head_in;
   logic [FCW-1:0]        fcount_ff, fcount_in;
   logic [TOTAL_BITS-1:0] ftotal_ff, ftotal_in;
   logic [SCW-1:0]        scount_ff [NUM_STACKS];
   logic [SCW-1:0]        scount_in [NUM_STACKS];
   logic [TOTAL_BITS-1:0] stotal_ff [NUM_STACKS];
   logic [TOTAL_BITS-1:0] stotal_in [NUM_STACKS];

   logic [TOTAL_BITS-1:0] cap_ff [NUM_CAPS];

   // Response register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SEL_BITS-1:0]   rsp_echo_ff, rsp_echo_in;
   logic [COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;
   logic [TOTAL_BITS-1:0] rsp_total_ff, rsp_total_in;
   logic                  rsp_err_ff, rsp_err_in;

   // Decoded command and bookkeeping views.
   logic                  req_ready;
   logic                  req_take;
   logic                  rsp_free;
   logic                  sel_bad;
   logic [SELW-1:0]       sidx;
   logic [SCW-1:0]        cur_cnt;
   logic [TOTAL_BITS-1:0] cur_tot;
   logic [TOTAL_BITS-1:0] cap_sel;
   logic                  fifo_full;
   logic                  fifo_empty;
   logic                  stack_full;
   logic [FAW:0]          tail_sum;
   logic [FAW-1:0]        tail;
   logic [FAW-1:0]        head_next;
   logic [SCW-1:0]        stack_ofs;
   logic [SAW-1:0]        stack_addr;
   logic [TOTAL_BITS-1:0] head_item;
   logic                  load_stop;

   // Memory ports.
   logic                   fifo_we;
   logic [FAW-1:0]         fifo_raddr;
   logic [WEIGHT_BITS-1:0] fifo_rdata;
   logic                   stack_we;
   logic [WEIGHT_BITS-1:0] stack_rdata;

   alu_req_type alu_req;
   alu_rsp_type alu_rsp;

   fcs_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   fcs_stores #(
      .FIFO_DEPTH  (FIFO_DEPTH),
      .NUM_STACKS  (NUM_STACKS),
      .STACK_DEPTH (STACK_DEPTH),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_stores (
      .clock       (clock),
      .fifo_we     (fifo_we),
      .fifo_waddr  (tail),
      .fifo_wdata  (weight_ff),
      .fifo_raddr  (fifo_raddr),
      .fifo_rdata  (fifo_rdata),
      .stack_we    (stack_we),
      .stack_addr  (stack_addr),
      .stack_wdata (fifo_rdata),
      .stack_rdata (stack_rdata)
   );

   // Handshakes. Capacity writes are always taken once reset is released.
   assign req_ready     = (state_ff == ST_IDLE) && !reset;
   assign req_if.ready  = req_ready;
   assign req_take      = req_if.valid && req_ready;
   assign rsp_free      = !rsp_valid_ff || rsp_if.ready;
   assign csr_if.ready  = !reset;

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.echo_stack   = rsp_echo_ff;
   assign rsp_if.item_count   = rsp_count_ff;
   assign rsp_if.total_weight = rsp_total_ff;
   assign rsp_if.error_flag   = rsp_err_ff;

   // The selected stack's view. When the index is bad these values are never used.
   assign sel_bad = {1'b0, sel_ff} >= (SEL_BITS + 1)'(NUM_STACKS);
   assign sidx    = sel_ff[SELW-1:0];
   assign cur_cnt = scount_ff[sidx];
   assign cur_tot = stotal_ff[sidx];
   assign cap_sel = ({1'b0, sel_ff} < (SEL_BITS + 1)'(NUM_CAPS)) ?
                    cap_ff[sel_ff[CAP_IDX_BITS-1:0]] : '0;

   assign fifo_full  = (fcount_ff == FCW'(FIFO_DEPTH));
   assign fifo_empty = (fcount_ff == '0);
   assign stack_full = (cur_cnt == SCW'(STACK_DEPTH));

   // Tail is head plus count, wrapped once; both are below the depth when adding.
   assign tail_sum  = (FAW + 1)'(head_ff) + (FAW + 1)'(fcount_ff);
   assign tail      = (tail_sum >= (FAW + 1)'(FIFO_DEPTH)) ?
                      FAW'(tail_sum - (FAW + 1)'(FIFO_DEPTH)) : FAW'(tail_sum);
   assign head_next = (head_ff == FAW'(FIFO_DEPTH - 1)) ? '0 : head_ff + FAW'(1);

   // A delete reads the entry below the count; a load writes the entry at the count.
   assign stack_ofs  = (state_ff == ST_EXEC) ? cur_cnt - SCW'(1) : cur_cnt;
   assign stack_addr = SAW'(sidx) * SAW'(STACK_DEPTH) + SAW'(stack_ofs);

   assign head_item = TOTAL_BITS'(fifo_rdata);
   assign load_stop = fifo_empty || stack_full || alu_rsp.over;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (kind_ff)
               KIND_LOAD:   state_in = sel_bad ? ST_DONE : ST_LOAD_CHK;
               KIND_DELETE: state_in = (sel_bad || cur_cnt == '0) ? ST_DONE : ST_DEL_SUB;
               default:     state_in = ST_DONE;
            endcase
         end
         ST_LOAD_CHK: begin
            state_in = load_stop ? ST_DONE : ST_LOAD_MOV;
         end
         ST_LOAD_MOV: begin
            state_in = ST_LOAD_CHK;
         end
         ST_DEL_SUB: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath control and register updates.
   always_comb begin
      kind_in      = kind_ff;
      weight_in    = weight_ff;
      sel_in       = sel_ff;
      err_in       = err_ff;
      head_in      = head_ff;
      fcount_in    = fcount_ff;
      ftotal_in    = ftotal_ff;
      scount_in    = scount_ff;
      stotal_in    = stotal_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_echo_in  = rsp_echo_ff;
      rsp_count_in = rsp_count_ff;
      rsp_total_in = rsp_total_ff;
      rsp_err_in   = rsp_err_ff;
      fifo_we      = 1'b0;
      stack_we     = 1'b0;
      fifo_raddr   = head_ff;
      alu_req.op    = ALU_ADD;
      alu_req.a     = ftotal_ff;
      alu_req.b     = TOTAL_BITS'(weight_ff);
      alu_req.limit = cap_sel;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               kind_in   = req_if.kind;
               weight_in = WEIGHT_BITS'(req_if.weight[WUSE-1:0]);
               sel_in    = req_if.stack_sel;
            end
         end
         ST_EXEC: begin
            err_in = 1'b0;
            case (kind_ff)
               KIND_ADD: begin
                  if (fifo_full) begin
                     err_in = 1'b1;
                  end else begin
                     fifo_we   = 1'b1;
                     fcount_in = fcount_ff + FCW'(1);
                     ftotal_in = alu_rsp.result;
                  end
               end
               KIND_LOAD, KIND_INFO: begin
                  err_in = sel_bad;
               end
               KIND_DELETE: begin
                  if (sel_bad) begin
                     err_in = 1'b1;
                  end else if (cur_cnt != '0) begin
                     scount_in[sidx] = cur_cnt - SCW'(1);
                  end
               end
               KIND_CLEAR: begin
                  head_in   = '0;
                  fcount_in = '0;
                  ftotal_in = '0;
                  for (int i = 0; i < NUM_STACKS; i++) begin
                     scount_in[i] = '0;
                     stotal_in[i] = '0;
                  end
               end
               default: begin
                  err_in = 1'b1;
               end
            endcase
         end
         ST_LOAD_CHK: begin
            // Would the head item still fit under the capacity?
            alu_req.op = ALU_ADD;
            alu_req.a  = cur_tot;
            alu_req.b  = head_item;
            if (!load_stop) begin
               stack_we        = 1'b1;
               scount_in[sidx] = cur_cnt + SCW'(1);
               stotal_in[sidx] = alu_rsp.result;
            end
         end
         ST_LOAD_MOV: begin
            // Retire the head and start reading the next one.
            alu_req.op = ALU_SUB;
            alu_req.a  = ftotal_ff;
            alu_req.b  = head_item;
            ftotal_in  = alu_rsp.result;
            head_in    = head_next;
            fcount_in  = fcount_ff - FCW'(1);
            fifo_raddr = head_next;
         end
         ST_DEL_SUB: begin
            alu_req.op      = ALU_SUB;
            alu_req.a       = cur_tot;
            alu_req.b       = TOTAL_BITS'(stack_rdata);
            stotal_in[sidx] = alu_rsp.result;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_err_in   = err_ff;
               rsp_echo_in  = '0;
               rsp_count_in = '0;
               rsp_total_in = '0;
               if (kind_ff inside {KIND_LOAD, KIND_DELETE, KIND_INFO}) begin
                  rsp_echo_in = sel_ff;
               end
               case (kind_ff)
                  KIND_ADD: begin
                     rsp_count_in = COUNT_BITS'(fcount_ff);
                     rsp_total_in = ftotal_ff;
                  end
                  KIND_LOAD, KIND_DELETE: begin
                     if (!sel_bad) begin
                        rsp_count_in = COUNT_BITS'(cur_cnt);
                     end
                  end
                  KIND_INFO: begin
                     if (!sel_bad) begin
                        rsp_count_in = COUNT_BITS'(cur_cnt);
                        rsp_total_in = cur_tot;
                     end
                  end
                  default: begin
                     rsp_count_in = '0;
                  end
               endcase
            end
         end
         default: begin
            err_in = err_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         fcount_ff    <= '0;
         ftotal_ff    <= '0;
         for (int i = 0; i < NUM_STACKS; i++) begin
            scount_ff[i] <= '0;
            stotal_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         fcount_ff    <= fcount_in;
         ftotal_ff    <= ftotal_in;
         scount_ff    <= scount_in;
         stotal_ff    <= stotal_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      weight_ff    <= weight_in;
      sel_ff       <= sel_in;
      err_ff       <= err_in;
      rsp_echo_ff  <= rsp_echo_in;
      rsp_count_ff <= rsp_count_in;
      rsp_total_ff <= rsp_total_in;
      rsp_err_ff   <= rsp_err_in;
   end

   // Capacity registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CAPS; i++) begin
            cap_ff[i] <= '0;
         end
      end else if (csr_if.valid && ({1'b0, csr_if.index} < (CSR_INDEX_BITS + 1)'(NUM_CAPS)))
      begin
         cap_ff[csr_if.index[CAP_IDX_BITS-1:0]] <= TOTAL_BITS'(csr_if.data);
      end
   end

endmodule
